// ===== rtl/frame_strip_sync_extract_macros.svh =====
// Assertion macros used by the top level of the frame strip/sync/extract block.
`ifndef FRAME_STRIP_SYNC_EXTRACT_MACROS_SVH
`define FRAME_STRIP_SYNC_EXTRACT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FSSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsse: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FSSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsse: next-cycle check failed");

`endif

// ===== rtl/fsse_pkg.sv =====
// Package with the types, constants and helpers of the frame strip/sync/extract block.
`timescale 1ns / 1ps
`default_nettype none

package fsse_pkg;

    localparam int MAX_SYNC_BYTES = 4;
    localparam int LENGTH_BITS    = 16;
    localparam int SYNC_LEN_W     = 3;
    localparam int MARKER_BYTES   = 4;
    localparam int MARKER_W       = 8 * MARKER_BYTES;
    localparam int MARKER_IDX_W   = $clog2(MARKER_BYTES);
    localparam int BYTE_W         = 8;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_INDEX_W    = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_STRIP_LENGTH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_LENGTH  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_MARKER_WORD  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH = CFG_INDEX_W'(3);

    typedef enum logic [2:0] {
        PH_STRIP = 3'b001,
        PH_SYNC  = 3'b010,
        PH_FRAME = 3'b100
    } phase_t;

    // Effective configuration as seen by the tracker.
    typedef struct packed {
        logic [LENGTH_BITS-1:0] strip_length;
        logic [SYNC_LEN_W-1:0]  sync_length;
        logic [MARKER_W-1:0]    marker_word;
        logic [LENGTH_BITS-1:0] frame_length;
    } cfg_t;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
    } result_t;

    // Effective values: the marker length saturates, a zero frame length acts as one.
    function automatic cfg_t effective_cfg(
        input logic [LENGTH_BITS-1:0] strip_length,
        input logic [SYNC_LEN_W-1:0]  sync_length,
        input logic [MARKER_W-1:0]    marker_word,
        input logic [LENGTH_BITS-1:0] frame_length
    );
        cfg_t c;
        c.strip_length = strip_length;
        c.sync_length  = (32'(sync_length) > MAX_SYNC_BYTES) ? SYNC_LEN_W'(MAX_SYNC_BYTES)
                                                             : sync_length;
        c.marker_word  = marker_word;
        c.frame_length = (frame_length == '0) ? LENGTH_BITS'(1) : frame_length;
        return c;
    endfunction

    // Expected marker byte at a match position; positions past the marker word read as zero.
    function automatic logic [BYTE_W-1:0] marker_byte(
        input logic [MARKER_W-1:0]   marker,
        input logic [SYNC_LEN_W-1:0] pos
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        if (32'(pos) < MARKER_BYTES)
        begin
            b = marker[BYTE_W * MARKER_IDX_W'(pos) +: BYTE_W];
        end
        return b;
    endfunction

    // Phase that a restart enters.
    function automatic phase_t initial_phase(input cfg_t cfg);
        phase_t ph;
        if (cfg.strip_length != '0)
        begin
            ph = PH_STRIP;
        end
        else if (cfg.sync_length != '0)
        begin
            ph = PH_SYNC;
        end
        else
        begin
            ph = PH_FRAME;
        end
        return ph;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fsse_tracker.sv =====
// Phase tracker: strip counter, marker matcher, frame counter; one byte per step cycle.
`timescale 1ns / 1ps
`default_nettype none

module fsse_tracker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          restart,
    input  wire fsse_pkg::cfg_t                restart_cfg,
    input  wire fsse_pkg::cfg_t                cfg,
    input  wire logic                          step,
    input  wire logic [fsse_pkg::BYTE_W-1:0]   data_byte,
    output fsse_pkg::result_t                  res
);

    fsse_pkg::phase_t                         phase_reg, phase_next;
    logic [fsse_pkg::LENGTH_BITS-1:0]         strip_rem_reg, strip_rem_next;
    logic [fsse_pkg::SYNC_LEN_W-1:0]          marker_pos_reg, marker_pos_next;
    logic [fsse_pkg::LENGTH_BITS-1:0]         frame_pos_reg, frame_pos_next;

    logic [fsse_pkg::LENGTH_BITS-1:0]         strip_dec;
    logic [fsse_pkg::SYNC_LEN_W-1:0]          pos;
    logic [fsse_pkg::SYNC_LEN_W-1:0]          pos_inc;
    logic [fsse_pkg::LENGTH_BITS-1:0]         frame_inc;
    logic                                     frame_go;
    logic                                     last;

    always_comb
    begin
        strip_dec = (strip_rem_reg != '0) ? strip_rem_reg - 1'b1 : '0;
        pos       = (marker_pos_reg >= cfg.sync_length) ? '0 : marker_pos_reg;
        pos_inc   = pos + 1'b1;
        frame_inc = frame_pos_reg + 1'b1;
        last      = (frame_inc >= cfg.frame_length) || (frame_inc == '0);
    end

    always_comb
    begin
        phase_next      = phase_reg;
        strip_rem_next  = strip_rem_reg;
        marker_pos_next = marker_pos_reg;
        frame_pos_next  = frame_pos_reg;
        frame_go        = 1'b0;
        res             = '0;
        res.data        = data_byte;

        if (restart)
        begin
            // The restart starts from the configuration as it stands after the write.
            phase_next      = fsse_pkg::initial_phase(restart_cfg);
            strip_rem_next  = restart_cfg.strip_length;
            marker_pos_next = '0;
            frame_pos_next  = '0;
        end
        else if (step)
        begin
            case (phase_reg)
                fsse_pkg::PH_STRIP:
                begin
                    strip_rem_next = strip_dec;
                    if (strip_dec == '0)
                    begin
                        strip_rem_next = cfg.strip_length;
                        phase_next     = (cfg.sync_length != '0) ? fsse_pkg::PH_SYNC
                                                                 : fsse_pkg::PH_FRAME;
                    end
                end
                fsse_pkg::PH_SYNC:
                begin
                    if (cfg.sync_length == '0)
                    begin
                        // No marker to hunt: this byte already belongs to the frame.
                        frame_go = 1'b1;
                    end
                    else if (data_byte != fsse_pkg::marker_byte(cfg.marker_word, pos))
                    begin
                        marker_pos_next = '0;
                    end
                    else if (pos_inc >= cfg.sync_length)
                    begin
                        marker_pos_next = '0;
                        phase_next      = fsse_pkg::PH_FRAME;
                    end
                    else
                    begin
                        marker_pos_next = pos_inc;
                    end
                end
                fsse_pkg::PH_FRAME:
                begin
                    frame_go = 1'b1;
                end
                default:
                begin
                    phase_next = fsse_pkg::initial_phase(cfg);
                end
            endcase

            if (frame_go)
            begin
                res.emit  = 1'b1;
                res.first = (frame_pos_reg == '0);
                res.last  = last;
                if (last)
                begin
                    phase_next      = fsse_pkg::initial_phase(cfg);
                    strip_rem_next  = cfg.strip_length;
                    marker_pos_next = '0;
                    frame_pos_next  = '0;
                end
                else
                begin
                    phase_next     = fsse_pkg::PH_FRAME;
                    frame_pos_next = frame_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= fsse_pkg::PH_FRAME;
            strip_rem_reg  <= '0;
            marker_pos_reg <= '0;
            frame_pos_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            strip_rem_reg  <= strip_rem_next;
            marker_pos_reg <= marker_pos_next;
            frame_pos_reg  <= frame_pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/frame_strip_sync_extract.sv =====
// Top level of the frame strip/sync/extract block: ports, configuration, pipeline registers.
//
// Usage: raw stream bytes arrive on the data channel (data_valid, data_ready,
// data_byte), one transfer per byte. Each cycle of the stream discards
// strip_length bytes, hunts for a marker of sync_length bytes, then passes
// frame_length bytes out on the frame channel (frame_valid, frame_ready,
// frame_byte, frame_first, frame_last). Strip and marker bytes give no transfer.
// Path: an accepted byte is held in the input register, evaluated against the
// phase state by the tracker, and its frame transfer is offered from the result register.
// Throughput: one byte per cycle unless frame_ready stalls it, set by the single pass
// through the phase tracker between the input register and the result register.
// Stall: when frame_ready is low the result register holds its transfer, the
// input register holds the next byte, and data_ready drops once both are full.
// Reset: configuration returns to strip 0, no marker, frame length 1, both
// registers empty. A configuration write (cfg_wr_en) to a listed register restarts
// the cycle with the new value at the same edge. The user must write only while the
// block is idle, which it does not enforce; writes to an index beyond the list are ignored.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_strip_sync_extract_macros.svh"

module frame_strip_sync_extract (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [fsse_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [fsse_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              data_valid,
    output logic                                   data_ready,
    input  wire logic [fsse_pkg::BYTE_W-1:0]       data_byte,
    output logic                                   frame_valid,
    input  wire logic                              frame_ready,
    output logic [fsse_pkg::BYTE_W-1:0]            frame_byte,
    output logic                                   frame_first,
    output logic                                   frame_last
);

    // Configuration registers as written.
    logic [fsse_pkg::LENGTH_BITS-1:0] strip_length_reg, strip_length_next;
    logic [fsse_pkg::SYNC_LEN_W-1:0]  sync_length_reg, sync_length_next;
    logic [fsse_pkg::MARKER_W-1:0]    marker_word_reg, marker_word_next;
    logic [fsse_pkg::LENGTH_BITS-1:0] frame_length_reg, frame_length_next;

    fsse_pkg::cfg_t                   cfg;
    fsse_pkg::cfg_t                   restart_cfg;
    logic                             restart;

    // Input register and result register.
    logic                             in_valid_reg;
    logic [fsse_pkg::BYTE_W-1:0]      in_byte_reg;
    logic                             out_valid_reg;
    logic [fsse_pkg::BYTE_W-1:0]      out_byte_reg;
    logic                             out_first_reg;
    logic                             out_last_reg;

    logic                             advance;
    logic                             step;
    fsse_pkg::result_t                res;

    // A write to a listed register updates it and restarts the cycle.
    always_comb
    begin
        strip_length_next = strip_length_reg;
        sync_length_next  = sync_length_reg;
        marker_word_next  = marker_word_reg;
        frame_length_next = frame_length_reg;
        restart           = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                fsse_pkg::REG_STRIP_LENGTH:
                begin
                    strip_length_next = cfg_data[fsse_pkg::LENGTH_BITS-1:0];
                    restart           = 1'b1;
                end
                fsse_pkg::REG_SYNC_LENGTH:
                begin
                    sync_length_next = cfg_data[fsse_pkg::SYNC_LEN_W-1:0];
                    restart          = 1'b1;
                end
                fsse_pkg::REG_MARKER_WORD:
                begin
                    marker_word_next = cfg_data[fsse_pkg::MARKER_W-1:0];
                    restart          = 1'b1;
                end
                fsse_pkg::REG_FRAME_LENGTH:
                begin
                    frame_length_next = cfg_data[fsse_pkg::LENGTH_BITS-1:0];
                    restart           = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_length_reg <= '0;
            sync_length_reg  <= '0;
            marker_word_reg  <= '0;
            frame_length_reg <= fsse_pkg::LENGTH_BITS'(1);
        end
        else
        begin
            strip_length_reg <= strip_length_next;
            sync_length_reg  <= sync_length_next;
            marker_word_reg  <= marker_word_next;
            frame_length_reg <= frame_length_next;
        end
    end

    // The tracker runs on the stored values; a restart uses the values being written.
    always_comb
    begin
        cfg         = fsse_pkg::effective_cfg(strip_length_reg, sync_length_reg,
                                              marker_word_reg, frame_length_reg);
        restart_cfg = fsse_pkg::effective_cfg(strip_length_next, sync_length_next,
                                              marker_word_next, frame_length_next);
    end

    // The pipeline moves whenever the result register is free or being drained.
    assign advance    = !out_valid_reg || frame_ready;
    assign step       = in_valid_reg && advance;
    assign data_ready = !in_valid_reg || advance;

    fsse_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .restart_cfg (restart_cfg),
        .cfg         (cfg),
        .step        (step),
        .data_byte   (in_byte_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (data_ready)
            begin
                in_valid_reg <= data_valid;
            end
            if (advance)
            begin
                out_valid_reg <= res.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_ready && data_valid)
        begin
            in_byte_reg <= data_byte;
        end
        if (advance && res.emit)
        begin
            out_byte_reg  <= res.data;
            out_first_reg <= res.first;
            out_last_reg  <= res.last;
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame_byte  = out_byte_reg;
    assign frame_first = out_first_reg;
    assign frame_last  = out_last_reg;

    // A byte waiting behind a stalled result stays in the input register.
    `FSSE_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg))
    // An empty input register always takes a new byte.
    `FSSE_ASSERT_NOW(a_ready_when_empty, !in_valid_reg, data_ready)
    // The tracker produces a result only for a byte it is stepping on.
    `FSSE_ASSERT_NOW(a_emit_on_step, res.emit, step)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the frame strip, sync and extract block.
`timescale 1ns / 1ps

module tb;

    // The timeout is far above the slowest correct run: about 1500 bytes that
    // each meet the longest gap on both sides, the register writes and the long hold.
    localparam int LIMIT_CYCLES = 500_000;
    // A byte is evaluated from the input register after its transfer, which the drain covers.
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 250;
    localparam int RANDOM_BYTES = 1100;
    localparam int LONG_STRIP   = 100;
    localparam int LONG_FRAME   = 150;

    // Indexes past the register list; writes there must be ignored.
    localparam logic [fsse_pkg::CFG_INDEX_W-1:0] REG_PAST_LIST = fsse_pkg::CFG_INDEX_W'(4);
    localparam logic [fsse_pkg::CFG_INDEX_W-1:0] REG_TOP_INDEX = '1;

    typedef struct packed {
        logic [fsse_pkg::BYTE_W-1:0] data;
        logic                        first;
        logic                        last;
    } frame_beat_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [fsse_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fsse_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             data_valid;
    logic                             data_ready;
    logic [fsse_pkg::BYTE_W-1:0]      data_byte;
    logic                             frame_valid;
    logic                             frame_ready;
    logic [fsse_pkg::BYTE_W-1:0]      frame_byte;
    logic                             frame_first;
    logic                             frame_last;

    frame_strip_sync_extract uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_valid  (data_valid),
        .data_ready  (data_ready),
        .data_byte   (data_byte),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_byte  (frame_byte),
        .frame_first (frame_first),
        .frame_last  (frame_last)
    );

    // Our own copy of the register file, held at the widths the block keeps.
    logic [fsse_pkg::LENGTH_BITS-1:0] strip_len_q;
    logic [fsse_pkg::SYNC_LEN_W-1:0]  sync_len_q;
    logic [fsse_pkg::MARKER_W-1:0]    marker_q;
    logic [fsse_pkg::LENGTH_BITS-1:0] frame_len_q;

    // Tracked position in the strip, sync and frame cycle.
    fsse_pkg::phase_t                 trk_phase;
    logic [fsse_pkg::LENGTH_BITS-1:0] strip_left;
    logic [fsse_pkg::LENGTH_BITS-1:0] frame_pos;
    int unsigned                      match_pos;

    // Frame bytes that the block still owes us, oldest first.
    frame_beat_t pending_beats[$];

    int errors;
    int bytes_sent;
    int beats_checked;
    int cfg_writes;
    int input_stalls;
    int cycles;
    bit tx_idle_en;
    bit rx_idle_en;
    bit long_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction of the frame byte stream.
    // ------------------------------------------------------------------

    // A marker length above the supported maximum saturates.
    function automatic int unsigned marker_len();
        if (sync_len_q > fsse_pkg::MAX_SYNC_BYTES)
        begin
            return fsse_pkg::MAX_SYNC_BYTES;
        end
        return 32'(sync_len_q);
    endfunction

    // Marker bytes are taken from the low byte upward; beyond the word they read as zero.
    function automatic logic [fsse_pkg::BYTE_W-1:0] marker_at(input int unsigned pos);
        if (pos >= fsse_pkg::MARKER_BYTES)
        begin
            return '0;
        end
        return marker_q[fsse_pkg::BYTE_W * pos +: fsse_pkg::BYTE_W];
    endfunction

    // A frame length of zero behaves like a length of one.
    function automatic int unsigned frame_len_eff();
        if (frame_len_q == '0)
        begin
            return 1;
        end
        return 32'(frame_len_q);
    endfunction

    // Both reset and a write to a listed register start the cycle over.
    task automatic restart_cycle();
        if (strip_len_q != '0)
        begin
            trk_phase = fsse_pkg::PH_STRIP;
        end
        else if (marker_len() != 0)
        begin
            trk_phase = fsse_pkg::PH_SYNC;
        end
        else
        begin
            trk_phase = fsse_pkg::PH_FRAME;
        end
        strip_left = strip_len_q;
        match_pos  = 0;
        frame_pos  = '0;
    endtask

    // Advances the tracked cycle by one accepted byte and queues the frame
    // byte that it yields, if any.
    task automatic extract_step(input logic [fsse_pkg::BYTE_W-1:0] b);
        frame_beat_t                      beat;
        logic [fsse_pkg::LENGTH_BITS-1:0] next_pos;
        bit                               emit;
        emit = (trk_phase == fsse_pkg::PH_FRAME);
        if (trk_phase == fsse_pkg::PH_STRIP)
        begin
            // An empty counter discards the byte and ends the phase, just as
            // a count that runs out does.
            if (strip_left != '0)
            begin
                strip_left = strip_left - 1'b1;
            end
            if (strip_left == '0)
            begin
                strip_left = strip_len_q;
                if (marker_len() != 0)
                begin
                    trk_phase = fsse_pkg::PH_SYNC;
                end
                else
                begin
                    trk_phase = fsse_pkg::PH_FRAME;
                end
            end
        end
        else if (trk_phase == fsse_pkg::PH_SYNC)
        begin
            if (marker_len() == 0)
            begin
                // Without a marker the byte belongs to the frame at once.
                trk_phase = fsse_pkg::PH_FRAME;
                emit      = 1'b1;
            end
            else
            begin
                if (match_pos >= marker_len())
                begin
                    match_pos = 0;
                end
                // A mismatch drops back to the start of the marker, and the
                // offending byte is not compared against the first marker byte.
                if (b != marker_at(match_pos))
                begin
                    match_pos = 0;
                end
                else
                begin
                    match_pos++;
                    if (match_pos >= marker_len())
                    begin
                        match_pos = 0;
                        trk_phase = fsse_pkg::PH_FRAME;
                    end
                end
            end
        end
        if (emit)
        begin
            beat.data  = b;
            beat.first = (frame_pos == '0);
            next_pos   = frame_pos + 1'b1;
            beat.last  = (next_pos >= frame_len_eff()) || (next_pos == '0);
            frame_pos  = next_pos;
            pending_beats.push_back(beat);
            if (beat.last)
            begin
                restart_cycle();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driving the block.
    // ------------------------------------------------------------------

    // Most gaps and stalls are short; about one in ten is long.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Offers one byte and returns at the edge where its transfer happens.
    // Valid stays high afterwards, so back-to-back bytes are offered without a gap.
    task automatic send_byte(input logic [fsse_pkg::BYTE_W-1:0] b);
        int unsigned gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 99) < 25)
        begin
            gap = pick_gap();
        end
        repeat (gap)
        begin
            @(negedge clk);
            data_valid <= 1'b0;
        end
        @(negedge clk);
        data_valid <= 1'b1;
        data_byte  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!data_ready);
        bytes_sent++;
        extract_step(b);
    endtask

    // Stops offering, waits for every owed frame byte, then lets any bytes
    // that give no transfer work their way through the block.
    task automatic wait_idle();
        if (data_valid)
        begin
            @(negedge clk);
            data_valid <= 1'b0;
        end
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes one register while the block is idle and mirrors the write.
    task automatic write_reg(input logic [fsse_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fsse_pkg::CFG_DATA_W-1:0]  value);
        wait_idle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
        case (idx)
            fsse_pkg::REG_STRIP_LENGTH: strip_len_q = value[fsse_pkg::LENGTH_BITS-1:0];
            fsse_pkg::REG_SYNC_LENGTH:  sync_len_q  = value[fsse_pkg::SYNC_LEN_W-1:0];
            fsse_pkg::REG_MARKER_WORD:  marker_q    = value[fsse_pkg::MARKER_W-1:0];
            fsse_pkg::REG_FRAME_LENGTH: frame_len_q = value[fsse_pkg::LENGTH_BITS-1:0];
            default:                    return;
        endcase
        restart_cycle();
    endtask

    // During the marker hunt, usually offer the byte that the block is
    // waiting for; otherwise random noise, which also breaks partial matches.
    function automatic logic [fsse_pkg::BYTE_W-1:0] next_stream_byte();
        int unsigned pos;
        if (trk_phase == fsse_pkg::PH_SYNC && marker_len() != 0 && $urandom_range(0, 99) < 85)
        begin
            pos = (match_pos >= marker_len()) ? 0 : match_pos;
            return marker_at(pos);
        end
        return fsse_pkg::BYTE_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        stall_left  = 0;
        frame_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                frame_ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD - 1;
                frame_ready  <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 99) < 20)
            begin
                stall_left   = pick_gap() - 1;
                frame_ready <= 1'b0;
            end
            else
            begin
                frame_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: every frame transfer is matched against the oldest owed byte.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && data_valid && !data_ready)
        begin
            input_stalls++;
        end
        if (rst_n && frame_valid && frame_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: frame transfer with nothing owed, expected none, got byte %02h",
                         $time, frame_byte);
                errors++;
            end
            else
            begin
                want = pending_beats.pop_front();
                beats_checked++;
                if (frame_byte !== want.data)
                begin
                    $display("%0t: frame_byte expected %02h, got %02h",
                             $time, want.data, frame_byte);
                    errors++;
                end
                if (frame_first !== want.first)
                begin
                    $display("%0t: frame_first expected %0b, got %0b",
                             $time, want.first, frame_first);
                    errors++;
                end
                if (frame_last !== want.last)
                begin
                    $display("%0t: frame_last expected %0b, got %0b",
                             $time, want.last, frame_last);
                    errors++;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Out of reset the frame length is one, so every byte is a whole frame.
    task automatic test_reset_state();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        wait_idle();
    endtask

    // Two stripped bytes, then a marker hunt that sees a broken match: the
    // second A5 fails at the second position and is not retried as a first
    // byte, and 5A then fails at the first position.
    task automatic test_strip_and_resync();
        rx_idle_en = 1'b1;
        write_reg(fsse_pkg::REG_STRIP_LENGTH, 32'd2);
        write_reg(fsse_pkg::REG_SYNC_LENGTH, 32'd2);
        write_reg(fsse_pkg::REG_MARKER_WORD, 32'h0000_5AA5);
        write_reg(fsse_pkg::REG_FRAME_LENGTH, 32'd3);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'hA5);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hC3);
        send_byte(8'h3C);
        send_byte(8'h81);
        wait_idle();
    endtask

    // A marker length of seven saturates to four, and a zero frame length
    // acts as one. Upper data bits beyond each register's width are dropped.
    task automatic test_marker_saturation();
        tx_idle_en = 1'b1;
        write_reg(fsse_pkg::REG_STRIP_LENGTH, 32'hFFFF_0000);
        write_reg(fsse_pkg::REG_SYNC_LENGTH, 32'hFFFF_FFFF);
        write_reg(fsse_pkg::REG_MARKER_WORD, 32'hDEAD_BEEF);
        write_reg(fsse_pkg::REG_FRAME_LENGTH, 32'hFFFF_0000);
        send_byte(8'hEF);
        send_byte(8'hBE);
        send_byte(8'hAD);
        send_byte(8'hDE);
        send_byte(8'h77);
        wait_idle();
    endtask

    // Writes past the register list must neither change anything nor
    // restart a strip phase that is already under way.
    task automatic test_unlisted_index();
        write_reg(fsse_pkg::REG_STRIP_LENGTH, 32'd3);
        write_reg(fsse_pkg::REG_SYNC_LENGTH, 32'd0);
        write_reg(fsse_pkg::REG_FRAME_LENGTH, 32'd2);
        send_byte(8'h01);
        send_byte(8'h02);
        write_reg(REG_PAST_LIST, 32'h0000_0001);
        write_reg(REG_TOP_INDEX, 32'hFFFF_FFFF);
        send_byte(8'h03);
        send_byte(8'h80);
        send_byte(8'h7F);
        wait_idle();
    endtask

    // A long strip followed by a long frame, at full rate; the data bits
    // above the counter width are set and must be dropped.
    task automatic test_length_extremes();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_reg(fsse_pkg::REG_STRIP_LENGTH, {16'hFFFF, 16'(LONG_STRIP)});
        write_reg(fsse_pkg::REG_SYNC_LENGTH, 32'd0);
        write_reg(fsse_pkg::REG_FRAME_LENGTH, {16'h8000, 16'(LONG_FRAME)});
        repeat (LONG_STRIP + LONG_FRAME) send_byte(fsse_pkg::BYTE_W'($urandom));
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the block fills and drops data_ready.
    task automatic test_backpressure();
        write_reg(fsse_pkg::REG_STRIP_LENGTH, 32'd0);
        write_reg(fsse_pkg::REG_SYNC_LENGTH, 32'd0);
        write_reg(fsse_pkg::REG_FRAME_LENGTH, 32'd4);
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b1;
        long_hold_req = 1'b1;
        repeat (64) send_byte(fsse_pkg::BYTE_W'($urandom));
        wait_idle();
    endtask

    // Picks a new setting, mostly short lengths, with random upper data bits
    // and now and then a write past the register list.
    task automatic configure_random();
        int unsigned    s;
        int unsigned    f;
        logic [31:0]    junk;
        case ($urandom_range(0, 9))
            0:       s = 0;
            1:       s = $urandom_range(20, 60);
            default: s = $urandom_range(0, 6);
        endcase
        case ($urandom_range(0, 9))
            0:       f = 0;
            1:       f = $urandom_range(30, 80);
            default: f = $urandom_range(1, 12);
        endcase
        junk = $urandom;
        write_reg(fsse_pkg::REG_STRIP_LENGTH, {junk[31:16], 16'(s)});
        junk = $urandom;
        write_reg(fsse_pkg::REG_SYNC_LENGTH, {junk[31:3], 3'($urandom_range(0, 7))});
        write_reg(fsse_pkg::REG_MARKER_WORD, $urandom);
        junk = $urandom;
        write_reg(fsse_pkg::REG_FRAME_LENGTH, {junk[31:16], 16'(f)});
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(fsse_pkg::CFG_INDEX_W'($urandom_range(REG_PAST_LIST, REG_TOP_INDEX)),
                      $urandom);
        end
    endtask

    // Random settings, each followed by a stream that mostly carries the
    // right marker and random frame content.
    task automatic test_random_stream();
        int random_sent;
        int phase_bytes;
        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            configure_random();
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_idle_en  = ($urandom_range(0, 3) != 0);
            phase_bytes = $urandom_range(40, 160);
            repeat (phase_bytes) send_byte(next_stream_byte());
            random_sent += phase_bytes;
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        data_valid    = 1'b0;
        data_byte     = '0;
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b0;
        long_hold_req = 1'b0;
        errors        = 0;
        bytes_sent    = 0;
        beats_checked = 0;
        cfg_writes    = 0;
        input_stalls  = 0;
        cycles        = 0;

        // Register values after reset.
        strip_len_q = '0;
        sync_len_q  = '0;
        marker_q    = '0;
        frame_len_q = fsse_pkg::LENGTH_BITS'(1);
        restart_cycle();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_strip_and_resync();
        test_marker_saturation();
        test_unlisted_index();
        test_backpressure();
        test_length_extremes();
        test_random_stream();

        rx_idle_en = 1'b0;
        wait_idle();

        $display("Sent %0d bytes and checked %0d frame bytes across %0d register writes.",
                 bytes_sent, beats_checked, cfg_writes);
        $display("The input was held back on %0d cycles by output backpressure.",
                 input_stalls);
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== frame_strip_sync_extract.f =====
+incdir+rtl
rtl/fsse_pkg.sv
rtl/fsse_tracker.sv
rtl/frame_strip_sync_extract.sv
tb/tb.sv
